### design/ps2_host_interface_assert.svh
// Assertion macros for the PS/2 host port.
`ifndef PS2_HOST_INTERFACE_ASSERT_SVH
`define PS2_HOST_INTERFACE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PS2HI_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, checked outside reset.
`define PS2HI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

### design/ps2hi_pkg.sv
// Shared types and constants for the PS/2 host port.
`timescale 1ns / 1ps

package ps2hi_pkg;

  localparam int TIMER_BITS = 16;
  localparam int CFG_BITS   = 16;
  localparam int FRAME_BITS = 11;

  localparam logic [3:0] LAST_EDGE = 4'd10;
  localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

  localparam logic [CFG_BITS-1:0] RX_TIMEOUT_RESET = 16'd256;
  localparam logic [CFG_BITS-1:0] TX_TIMEOUT_RESET = 16'd4096;

  typedef enum logic [1:0] {
    CMD_EDGE = 2'd0,
    CMD_TICK = 2'd1,
    CMD_SEND = 2'd2,
    CMD_READ = 2'd3
  } cmd_t;

  typedef enum logic {
    REG_RX_TIMEOUT = 1'b0,
    REG_TX_TIMEOUT = 1'b1
  } reg_idx_t;

endpackage

### design/ps2_host_interface.sv
// PS/2 host port: event-driven frame receiver, command transmitter and timer.
// Usage:
//   Input channel (in_valid/in_ready) carries one event per item: a keyboard
//   clock falling edge with the sampled data level, a timer tick, a send
//   request with a command byte, or a read of the received code.
//   Result channel (out_valid/out_ready) returns exactly one item per event:
//   the line drive level, read status and code, and status flags.
//   Configuration port (cfg_we/cfg_index/cfg_wdata) sets the receive and
//   transmit timeouts in ticks; write only while no event is in flight.
// Timing:
//   An event is handled in the cycle it is accepted; its result is held in
//   the output register from the next cycle on.
//   One event per cycle is sustained while out_ready stays high; the single
//   output register sets that figure.
// Reset:
//   rst_n low clears all port state, empties the output register and loads
//   the timeout defaults (256 receive, 4096 transmit).
// Stall:
//   With out_ready low the result holds and in_ready drops, so no further
//   event is taken until the result is consumed.
`timescale 1ns / 1ps
`include "ps2_host_interface_assert.svh"

module ps2_host_interface (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_cmd,
  input  logic                          in_data_level,
  input  logic [7:0]                    in_send_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_drive_data_low,
  output logic [7:0]                    out_code,
  output logic                          out_code_valid,
  output logic                          out_frame_error,
  output logic                          out_code_pending,
  output logic                          out_sending,
  output logic                          out_timed_out,
  output logic                          out_send_done,
  output logic                          out_ack_seen,
  output logic                          out_send_rejected,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [ps2hi_pkg::CFG_BITS-1:0] cfg_wdata
);

  logic [ps2hi_pkg::CFG_BITS-1:0]   rx_limit_r, tx_limit_r;
  logic [ps2hi_pkg::FRAME_BITS-1:0] frame_r, frame_nxt;
  logic [3:0]                       bit_cnt_r, bit_cnt_nxt;
  logic                             pending_r, pending_nxt;
  logic                             tx_r, tx_nxt;
  logic                             tmr_run_r, tmr_run_nxt;
  logic [ps2hi_pkg::TIMER_BITS-1:0] tmr_cnt_r, tmr_cnt_nxt;
  logic                             tmr_sel_r, tmr_sel_nxt;

  logic                             out_valid_r;
  logic                             drive_r, drive_nxt;
  logic [7:0]                       code_r, code_nxt;
  logic                             valid_r, valid_nxt;
  logic                             ferr_r, ferr_nxt;
  logic                             tout_r, tout_nxt;
  logic                             done_r, done_nxt;
  logic                             ack_r, ack_nxt;
  logic                             rej_r, rej_nxt;

  logic                             in_fire;
  logic [ps2hi_pkg::TIMER_BITS-1:0] tmr_inc;
  logic [ps2hi_pkg::CFG_BITS-1:0]   tmr_lim;
  logic [3:0]                       drive_idx;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign tmr_inc = (tmr_cnt_r == ps2hi_pkg::TIMER_MAX) ? tmr_cnt_r
                                                       : tmr_cnt_r + 1'b1;
  assign tmr_lim = tmr_sel_r ? tx_limit_r : rx_limit_r;

  always_comb begin
    frame_nxt   = frame_r;
    bit_cnt_nxt = bit_cnt_r;
    pending_nxt = pending_r;
    tx_nxt      = tx_r;
    tmr_run_nxt = tmr_run_r;
    tmr_cnt_nxt = tmr_cnt_r;
    tmr_sel_nxt = tmr_sel_r;
    code_nxt    = 8'd0;
    valid_nxt   = 1'b0;
    ferr_nxt    = 1'b0;
    tout_nxt    = 1'b0;
    done_nxt    = 1'b0;
    ack_nxt     = 1'b0;
    rej_nxt     = 1'b0;
    unique case (ps2hi_pkg::cmd_t'(in_cmd))
      ps2hi_pkg::CMD_EDGE: begin
        // first edge of a frame restarts the timer on the receive limit
        if (bit_cnt_r == 4'd0) begin
          tmr_run_nxt = 1'b1;
          tmr_cnt_nxt = '0;
          tmr_sel_nxt = 1'b0;
        end
        if (tx_r) begin
          if (bit_cnt_r == ps2hi_pkg::LAST_EDGE) begin
            tx_nxt      = 1'b0;
            tmr_run_nxt = 1'b0;
            done_nxt    = 1'b1;
            ack_nxt     = !in_data_level;
            bit_cnt_nxt = 4'd0;
          end else begin
            bit_cnt_nxt = bit_cnt_r + 4'd1;
          end
        end else if (!pending_r) begin
          if (bit_cnt_r <= ps2hi_pkg::LAST_EDGE) begin
            frame_nxt[bit_cnt_r] = in_data_level;
          end
          if (bit_cnt_r == ps2hi_pkg::LAST_EDGE) begin
            tmr_run_nxt = 1'b0;
            pending_nxt = 1'b1;
            bit_cnt_nxt = 4'd0;
          end else begin
            bit_cnt_nxt = bit_cnt_r + 4'd1;
          end
        end
      end
      ps2hi_pkg::CMD_TICK: begin
        if (tmr_run_r) begin
          tmr_cnt_nxt = tmr_inc;
          if ((tmr_inc >= ps2hi_pkg::TIMER_BITS'(tmr_lim)) ||
              (tmr_inc == ps2hi_pkg::TIMER_MAX)) begin
            tmr_run_nxt = 1'b0;
            bit_cnt_nxt = 4'd0;
            tx_nxt      = 1'b0;
            tout_nxt    = 1'b1;
          end
        end
      end
      ps2hi_pkg::CMD_SEND: begin
        if (tx_r) begin
          rej_nxt = 1'b1;
        end else begin
          // byte and odd parity overwrite the low bits; upper bits hold
          frame_nxt   = {frame_r[10:9], ~^in_send_byte, in_send_byte};
          tx_nxt      = 1'b1;
          bit_cnt_nxt = 4'd0;
          tmr_run_nxt = 1'b1;
          tmr_cnt_nxt = '0;
          tmr_sel_nxt = 1'b1;
        end
      end
      ps2hi_pkg::CMD_READ: begin
        if (pending_r) begin
          if (!frame_r[0] && frame_r[10]) begin
            frame_nxt = {1'b0, frame_r[10:1]};
            if ((^frame_r[8:1]) ^ frame_r[9]) begin
              code_nxt  = frame_r[8:1];
              valid_nxt = 1'b1;
            end
          end
          ferr_nxt    = !valid_nxt;
          pending_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // drive level follows the state after the event
  assign drive_idx = bit_cnt_nxt - 4'd1;
  always_comb begin
    drive_nxt = 1'b0;
    if (tx_nxt) begin
      if (bit_cnt_nxt == 4'd0) begin
        drive_nxt = 1'b1;
      end else if (bit_cnt_nxt <= 4'd9) begin
        drive_nxt = !frame_nxt[drive_idx];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_limit_r  <= ps2hi_pkg::RX_TIMEOUT_RESET;
      tx_limit_r  <= ps2hi_pkg::TX_TIMEOUT_RESET;
      frame_r     <= '0;
      bit_cnt_r   <= 4'd0;
      pending_r   <= 1'b0;
      tx_r        <= 1'b0;
      tmr_run_r   <= 1'b0;
      tmr_cnt_r   <= '0;
      tmr_sel_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (ps2hi_pkg::reg_idx_t'(cfg_index))
          ps2hi_pkg::REG_RX_TIMEOUT: rx_limit_r <= cfg_wdata;
          ps2hi_pkg::REG_TX_TIMEOUT: tx_limit_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_fire) begin
        frame_r   <= frame_nxt;
        bit_cnt_r <= bit_cnt_nxt;
        pending_r <= pending_nxt;
        tx_r      <= tx_nxt;
        tmr_run_r <= tmr_run_nxt;
        tmr_cnt_r <= tmr_cnt_nxt;
        tmr_sel_r <= tmr_sel_nxt;
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, loaded with each accepted item
  always_ff @(posedge clk) begin
    if (in_fire) begin
      drive_r <= drive_nxt;
      code_r  <= code_nxt;
      valid_r <= valid_nxt;
      ferr_r  <= ferr_nxt;
      tout_r  <= tout_nxt;
      done_r  <= done_nxt;
      ack_r   <= ack_nxt;
      rej_r   <= rej_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_drive_data_low = drive_r;
  assign out_code           = code_r;
  assign out_code_valid     = valid_r;
  assign out_frame_error    = ferr_r;
  assign out_code_pending   = pending_r;
  assign out_sending        = tx_r;
  assign out_timed_out      = tout_r;
  assign out_send_done      = done_r;
  assign out_ack_seen       = ack_r;
  assign out_send_rejected  = rej_r;

  `PS2HI_ASSERT_NOW(a_read_excl, out_valid_r, !(valid_r && ferr_r))
  `PS2HI_ASSERT_NOW(a_code_only_valid, out_valid_r && !valid_r, code_r == 8'd0)
  `PS2HI_ASSERT_NOW(a_done_idle, out_valid_r && (done_r || tout_r), !tx_r && !drive_r)
  `PS2HI_ASSERT_NEXT(a_send_starts, in_fire && in_cmd == ps2hi_pkg::CMD_SEND && !tx_r,
                     tx_r && drive_r && bit_cnt_r == 4'd0)

endmodule

### sim/ps2_host_interface_tb.sv
// Self-checking testbench for the PS/2 host port: random events against a predictor.
`timescale 1ns / 1ps

module ps2_host_interface_tb;

  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    ps2hi_pkg::cmd_t op;
    logic            level;
    logic [7:0]      cmd_byte;
  } port_op_t;

  typedef struct packed {
    logic       drive_data_low;
    logic [7:0] code;
    logic       code_valid;
    logic       frame_error;
    logic       code_pending;
    logic       sending;
    logic       timed_out;
    logic       send_done;
    logic       ack_seen;
    logic       send_rejected;
  } port_result_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  ps2hi_pkg::cmd_t                in_cmd = ps2hi_pkg::CMD_READ;
  logic                           in_data_level = 1'b0;
  logic [7:0]                     in_send_byte = 8'h00;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic                           out_drive_data_low;
  logic [7:0]                     out_code;
  logic                           out_code_valid;
  logic                           out_frame_error;
  logic                           out_code_pending;
  logic                           out_sending;
  logic                           out_timed_out;
  logic                           out_send_done;
  logic                           out_ack_seen;
  logic                           out_send_rejected;
  logic                           cfg_we = 1'b0;
  ps2hi_pkg::reg_idx_t            cfg_index = ps2hi_pkg::REG_RX_TIMEOUT;
  logic [ps2hi_pkg::CFG_BITS-1:0] cfg_wdata = '0;

  ps2_host_interface dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_cmd(in_cmd),
    .in_data_level(in_data_level),
    .in_send_byte(in_send_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_drive_data_low(out_drive_data_low),
    .out_code(out_code),
    .out_code_valid(out_code_valid),
    .out_frame_error(out_frame_error),
    .out_code_pending(out_code_pending),
    .out_sending(out_sending),
    .out_timed_out(out_timed_out),
    .out_send_done(out_send_done),
    .out_ack_seen(out_ack_seen),
    .out_send_rejected(out_send_rejected),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  // Predictor state of the port
  logic [ps2hi_pkg::FRAME_BITS-1:0] rx_frame;
  logic [3:0]                       bit_idx;
  logic                             rx_held;
  logic                             tx_busy;
  logic                             tmr_on;
  logic [ps2hi_pkg::TIMER_BITS-1:0] tmr_count;
  logic                             tmr_tx;
  logic [ps2hi_pkg::CFG_BITS-1:0]   rx_limit;
  logic [ps2hi_pkg::CFG_BITS-1:0]   tx_limit;

  port_op_t     op_q[$];
  port_result_t result_q[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int queued_total = 0;
  int n_accepted = 0;
  int n_results = 0;
  int err_count = 0;
  int quiet_cycles = 0;
  int n_codes = 0, n_ferr = 0, n_tout = 0, n_done = 0, n_ack = 0, n_rej = 0;

  function automatic port_result_t advance_port(ps2hi_pkg::cmd_t op, logic lvl,
                                                logic [7:0] data_byte);
    port_result_t r;
    logic [ps2hi_pkg::CFG_BITS-1:0] lim;
    r = '0;
    case (op)
      ps2hi_pkg::CMD_EDGE: begin
        // the first edge of any frame restarts the timer on the receive limit
        if (bit_idx == 4'd0) begin
          tmr_on = 1'b1;
          tmr_count = '0;
          tmr_tx = 1'b0;
        end
        if (tx_busy) begin
          if (bit_idx == ps2hi_pkg::LAST_EDGE) begin
            tx_busy = 1'b0;
            tmr_on = 1'b0;
            r.send_done = 1'b1;
            r.ack_seen = ~lvl;
            bit_idx = 4'd0;
          end else begin
            bit_idx = bit_idx + 4'd1;
          end
        end else if (!rx_held) begin
          if (bit_idx <= ps2hi_pkg::LAST_EDGE) rx_frame[bit_idx] = lvl;
          if (bit_idx == ps2hi_pkg::LAST_EDGE) begin
            tmr_on = 1'b0;
            rx_held = 1'b1;
            bit_idx = 4'd0;
          end else begin
            bit_idx = bit_idx + 4'd1;
          end
        end
      end
      ps2hi_pkg::CMD_TICK: begin
        if (tmr_on) begin
          lim = tmr_tx ? tx_limit : rx_limit;
          if (tmr_count != ps2hi_pkg::TIMER_MAX) tmr_count = tmr_count + 1'b1;
          if (tmr_count >= lim || tmr_count == ps2hi_pkg::TIMER_MAX) begin
            tmr_on = 1'b0;
            bit_idx = 4'd0;
            tx_busy = 1'b0;
            r.timed_out = 1'b1;
          end
        end
      end
      ps2hi_pkg::CMD_SEND: begin
        if (tx_busy) begin
          r.send_rejected = 1'b1;
        end else begin
          // byte and odd parity overwrite the low bits of the receive register
          rx_frame[8:0] = {~^data_byte, data_byte};
          tx_busy = 1'b1;
          bit_idx = 4'd0;
          tmr_on = 1'b1;
          tmr_count = '0;
          tmr_tx = 1'b1;
        end
      end
      ps2hi_pkg::CMD_READ: begin
        if (rx_held) begin
          if (!rx_frame[0] && rx_frame[10]) begin
            rx_frame = rx_frame >> 1;
            if ((^rx_frame[7:0]) ^ rx_frame[8]) begin
              r.code = rx_frame[7:0];
              r.code_valid = 1'b1;
            end
          end
          r.frame_error = ~r.code_valid;
          rx_held = 1'b0;
        end
      end
    endcase
    if (tx_busy && bit_idx == 4'd0) r.drive_data_low = 1'b1;
    else if (tx_busy && bit_idx <= 4'd9) r.drive_data_low = ~rx_frame[bit_idx - 4'd1];
    r.code_pending = rx_held;
    r.sending = tx_busy;
    return r;
  endfunction

  task automatic push_op(ps2hi_pkg::cmd_t op, logic lvl, logic [7:0] data_byte);
    port_op_t o;
    o.op = op;
    o.level = lvl;
    o.cmd_byte = data_byte;
    op_q.push_back(o);
    queued_total++;
  endtask

  task automatic push_tick();
    push_op(ps2hi_pkg::CMD_TICK, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
  endtask

  // Mostly well-formed frames; some carry a bad start, stop or parity bit, some stop short.
  task automatic add_rx_frame();
    logic [7:0]  d;
    logic [10:0] f;
    int          flaw;
    int          n_edges;
    d = 8'($urandom_range(0, 255));
    f = {1'b1, ~^d, d, 1'b0};
    flaw = $urandom_range(0, 9);
    if (flaw == 0) f[0] = 1'b1;
    else if (flaw == 1) f[10] = 1'b0;
    else if (flaw == 2) f[9] = ~f[9];
    n_edges = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 10) : 11;
    for (int i = 0; i < n_edges; i++) begin
      if ($urandom_range(0, 3) == 0) push_tick();
      push_op(ps2hi_pkg::CMD_EDGE, f[i], 8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 9) != 0)
      push_op(ps2hi_pkg::CMD_READ, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
  endtask

  // A command send with random line levels, sometimes a refused second send or a cut-off.
  task automatic add_tx_frame();
    int n_edges;
    int rej_at;
    push_op(ps2hi_pkg::CMD_SEND, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    n_edges = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 10) : 11;
    rej_at = $urandom_range(0, 20);
    for (int i = 0; i < n_edges; i++) begin
      if ($urandom_range(0, 3) == 0) push_tick();
      if (i == rej_at)
        push_op(ps2hi_pkg::CMD_SEND, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      push_op(ps2hi_pkg::CMD_EDGE, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic add_burst();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) begin
      add_rx_frame();
    end else if (sel < 75) begin
      add_tx_frame();
    end else if (sel < 85) begin
      repeat ($urandom_range(1, 40)) push_tick();
    end else begin
      repeat ($urandom_range(1, 4))
        push_op(ps2hi_pkg::cmd_t'(2'($urandom_range(0, 3))), 1'($urandom_range(0, 1)),
                8'($urandom_range(0, 255)));
    end
  endtask

  task automatic wait_drained();
    while (n_accepted != queued_total || result_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_limits(logic [ps2hi_pkg::CFG_BITS-1:0] rx,
                            logic [ps2hi_pkg::CFG_BITS-1:0] tx);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= ps2hi_pkg::REG_RX_TIMEOUT;
    cfg_wdata <= rx;
    rx_limit = rx;
    @(posedge clk);
    cfg_index <= ps2hi_pkg::REG_TX_TIMEOUT;
    cfg_wdata <= tx;
    tx_limit = tx;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(logic [ps2hi_pkg::CFG_BITS-1:0] rx,
                           logic [ps2hi_pkg::CFG_BITS-1:0] tx,
                           int send_pct, int recv_pct, int n_items);
    int start;
    wait_drained();
    set_limits(rx, tx);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    start = queued_total;
    while (queued_total - start < n_items) add_burst();
  endtask

  task automatic compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin : drive_ops
    port_op_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        result_q.push_back(advance_port(in_cmd, in_data_level, in_send_byte));
        n_accepted++;
      end
      // hold the payload until the item is taken
      if (!in_valid || in_ready) begin
        if (op_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = op_q.pop_front();
          in_valid <= 1'b1;
          in_cmd <= nxt.op;
          in_data_level <= nxt.level;
          in_send_byte <= nxt.cmd_byte;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_results
    port_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_results++;
        if (result_q.size() == 0) begin
          $error("result arrived with no pending expectation");
          err_count++;
        end else begin
          want = result_q.pop_front();
          compare_field("drive_data_low", 8'(want.drive_data_low), 8'(out_drive_data_low));
          compare_field("code", want.code, out_code);
          compare_field("code_valid", 8'(want.code_valid), 8'(out_code_valid));
          compare_field("frame_error", 8'(want.frame_error), 8'(out_frame_error));
          compare_field("code_pending", 8'(want.code_pending), 8'(out_code_pending));
          compare_field("sending", 8'(want.sending), 8'(out_sending));
          compare_field("timed_out", 8'(want.timed_out), 8'(out_timed_out));
          compare_field("send_done", 8'(want.send_done), 8'(out_send_done));
          compare_field("ack_seen", 8'(want.ack_seen), 8'(out_ack_seen));
          compare_field("send_rejected", 8'(want.send_rejected), 8'(out_send_rejected));
          n_codes += int'(want.code_valid);
          n_ferr += int'(want.frame_error);
          n_tout += int'(want.timed_out);
          n_done += int'(want.send_done);
          n_ack += int'(want.ack_seen);
          n_rej += int'(want.send_rejected);
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("ps2_host_interface_tb failed");
      $finish;
    end
  end

  initial begin
    rx_frame = '0;
    bit_idx = 4'd0;
    rx_held = 1'b0;
    tx_busy = 1'b0;
    tmr_on = 1'b0;
    tmr_count = '0;
    tmr_tx = 1'b0;
    rx_limit = ps2hi_pkg::RX_TIMEOUT_RESET;
    tx_limit = ps2hi_pkg::TX_TIMEOUT_RESET;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 21;
    recv_idle_pct = 72;
    set_limits(16'd1, 16'd2);
    // empty read, idle tick, a clean 0xFF frame, then an edge while it waits
    push_op(ps2hi_pkg::CMD_READ, 1'b0, 8'h00);
    push_op(ps2hi_pkg::CMD_TICK, 1'b1, 8'hFF);
    for (int i = 0; i < 11; i++)
      push_op(ps2hi_pkg::CMD_EDGE, (i == 0) ? 1'b0 : 1'b1, 8'h00);
    push_op(ps2hi_pkg::CMD_EDGE, 1'b1, 8'hFF);
    // a send clobbers the waiting frame, so the read must flag it
    push_op(ps2hi_pkg::CMD_SEND, 1'b0, 8'hA5);
    push_op(ps2hi_pkg::CMD_READ, 1'b0, 8'h00);
    push_op(ps2hi_pkg::CMD_SEND, 1'b1, 8'h00);
    push_op(ps2hi_pkg::CMD_TICK, 1'b0, 8'h00);
    push_op(ps2hi_pkg::CMD_TICK, 1'b0, 8'h00);
    push_op(ps2hi_pkg::CMD_EDGE, 1'b0, 8'h00);
    push_op(ps2hi_pkg::CMD_READ, 1'b1, 8'hFF);

    run_phase(16'd1, 16'd2, 21, 72, 260);
    run_phase(16'd20, 16'd65535, 21, 72, 280);
    run_phase(16'd0, 16'd0, 72, 21, 280);
    run_phase(16'd65535, 16'd30, 72, 21, 280);
    run_phase(16'd8, 16'd150, 0, 0, 280);
    run_phase(16'd3, 16'd13, 0, 0, 280);
    wait_drained();
    repeat (5) @(posedge clk);

    $display("Ran %0d port events over six timeout settings: %0d good codes, %0d bad frames,",
             n_accepted, n_codes, n_ferr);
    $display("%0d finished sends (%0d acked), %0d timeouts, %0d refused sends.",
             n_done, n_ack, n_tout, n_rej);
    if (err_count == 0) begin
      $display("ps2_host_interface_tb passed");
    end else begin
      $display("ps2_host_interface_tb failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/ps2hi_pkg.sv
design/ps2_host_interface.sv
sim/ps2_host_interface_tb.sv
